// File: sv/cds_pkg.sv
// ----------------------------------------------------------------------------
// cds_pkg
// Shared types, constants and calendar helper functions for the date stepper.
// ----------------------------------------------------------------------------
package cds_pkg;

  // field widths
  localparam int YEAR_W   = 14;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int WDAY_W   = 3;
  localparam int JDAYS_W  = 16;
  localparam int KIND_W   = 3;

  // configuration of the counter
  localparam int JUMP_WIDTH = 16;
  localparam int YEAR_MAX   = 9999;

  // year split into century and year-in-century, both below 100
  localparam int CENT_W      = 7;
  localparam int CENT        = 100;
  localparam int RECIP_100   = 5243;
  localparam int RECIP_SHIFT = 19;
  localparam int PROD_W      = 27;

  // reset date
  localparam int YEAR_RESET = (2000 > YEAR_MAX) ? YEAR_MAX : 2000;
  localparam int HI_RESET   = YEAR_RESET / CENT;
  localparam int LO_RESET   = YEAR_RESET % CENT;

  // zeller sum width
  localparam int SUM_W = 10;

  typedef enum logic [KIND_W-1:0] {
    KIND_FWD   = 3'd0,
    KIND_BACK  = 3'd1,
    KIND_JFWD  = 3'd2,
    KIND_JBACK = 3'd3,
    KIND_LOAD  = 3'd4
  } kind_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_CAPTURE,
    OP_SPLIT_HI,
    OP_SPLIT_LO,
    OP_CLIP,
    OP_FWD,
    OP_BACK,
    OP_WD_SUM,
    OP_WD_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   load_date;
    logic   unit_step;
  } cds_cmd_t;

  typedef struct packed {
    logic walk_done;
  } cds_stat_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      4'd2:    len = leap ? DAY_W'(29) : DAY_W'(28);
      4'd4:    len = DAY_W'(30);
      4'd6:    len = DAY_W'(30);
      4'd9:    len = DAY_W'(30);
      4'd11:   len = DAY_W'(30);
      default: len = DAY_W'(31);
    endcase
    return len;
  endfunction

  // floor(13 * (m + 1) / 5) for the shifted months 3..14
  function automatic logic [5:0] zeller_month(input logic [MONTH_W-1:0] mm);
    logic [5:0] v;
    case (mm)
      4'd3:    v = 6'd10;
      4'd4:    v = 6'd13;
      4'd5:    v = 6'd15;
      4'd6:    v = 6'd18;
      4'd7:    v = 6'd20;
      4'd8:    v = 6'd23;
      4'd9:    v = 6'd26;
      4'd10:   v = 6'd28;
      4'd11:   v = 6'd31;
      4'd12:   v = 6'd33;
      4'd13:   v = 6'd36;
      4'd14:   v = 6'd39;
      default: v = 6'd0;
    endcase
    return v;
  endfunction

endpackage

// File: sv/cds_ctrl.sv
// ----------------------------------------------------------------------------
// cds_ctrl
// Command sequencer: accepts a command, walks the datapath through load,
// month walk and weekday steps, and hands the result to the output register.
// ----------------------------------------------------------------------------
module cds_ctrl
  import cds_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [KIND_W-1:0] in_kind,
  output logic              out_valid,
  input  logic              out_stall,
  output cds_cmd_t          cmd,
  input  cds_stat_t         stat
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SPLIT_HI,
    S_SPLIT_LO,
    S_CLIP,
    S_FWD,
    S_BACK,
    S_WD_SUM,
    S_WD_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r & out_stall;
    cmd.op        = OP_NOP;
    cmd.load_date = 1'b0;
    cmd.unit_step = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = OP_CAPTURE;
          case (kind_t'(in_kind))
            KIND_FWD: begin
              cmd.unit_step = 1'b1;
              state_nxt     = S_FWD;
            end
            KIND_BACK: begin
              cmd.unit_step = 1'b1;
              state_nxt     = S_BACK;
            end
            KIND_JFWD:  state_nxt = S_FWD;
            KIND_JBACK: state_nxt = S_BACK;
            KIND_LOAD: begin
              cmd.load_date = 1'b1;
              state_nxt     = S_SPLIT_HI;
            end
            default:    state_nxt = S_WD_SUM;
          endcase
        end
      end
      S_SPLIT_HI: begin
        cmd.op    = OP_SPLIT_HI;
        state_nxt = S_SPLIT_LO;
      end
      S_SPLIT_LO: begin
        cmd.op    = OP_SPLIT_LO;
        state_nxt = S_CLIP;
      end
      S_CLIP: begin
        cmd.op    = OP_CLIP;
        state_nxt = S_WD_SUM;
      end
      S_FWD: begin
        cmd.op = OP_FWD;
        if (stat.walk_done) begin
          state_nxt = S_WD_SUM;
        end
      end
      S_BACK: begin
        cmd.op = OP_BACK;
        if (stat.walk_done) begin
          state_nxt = S_WD_SUM;
        end
      end
      S_WD_SUM: begin
        cmd.op    = OP_WD_SUM;
        state_nxt = S_WD_OUT;
      end
      S_WD_OUT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.op        = OP_WD_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// File: sv/cds_datapath.sv
// ----------------------------------------------------------------------------
// cds_datapath
// Date registers, remaining-day counter, month walk, century split and
// weekday arithmetic, plus the result register.
// ----------------------------------------------------------------------------
module cds_datapath
  import cds_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cds_cmd_t           cmd,
  output cds_stat_t          stat,
  input  logic [JDAYS_W-1:0] in_jump_days,
  input  logic [YEAR_W-1:0]  in_load_year,
  input  logic [MONTH_W-1:0] in_load_month,
  input  logic [DAY_W-1:0]   in_load_day,
  output logic [YEAR_W-1:0]  out_year_now,
  output logic [MONTH_W-1:0] out_month_now,
  output logic [DAY_W-1:0]   out_day_now,
  output logic [WDAY_W-1:0]  out_weekday,
  output logic               out_leap_year,
  output logic               out_limit_hit
);

  localparam logic [YEAR_W-1:0] YMAX = YEAR_W'(YEAR_MAX);

  logic [YEAR_W-1:0]     year_r, year_nxt;
  logic [MONTH_W-1:0]    month_r, month_nxt;
  logic [DAY_W-1:0]      day_r, day_nxt;
  logic [CENT_W-1:0]     hi_r, hi_nxt;
  logic [CENT_W-1:0]     lo_r, lo_nxt;
  logic [JUMP_WIDTH-1:0] n_r, n_nxt;
  logic                  limit_r, limit_nxt;
  logic [SUM_W-1:0]      sum_r, sum_nxt;

  logic [YEAR_W-1:0]  yout_r;
  logic [MONTH_W-1:0] mout_r;
  logic [DAY_W-1:0]   dout_r;
  logic [WDAY_W-1:0]  wout_r;
  logic               lout_r;
  logic               hout_r;

  logic                  leap;
  logic [DAY_W-1:0]      len;
  logic [DAY_W-1:0]      len_prev;
  logic [JUMP_WIDTH:0]   fwd_sum;
  logic                  fwd_fits;
  logic                  fwd_end;
  logic                  back_fits;
  logic                  back_end;
  logic [PROD_W-1:0]     prod;
  logic [MONTH_W-1:0]    mm;
  logic [CENT_W-1:0]     zk;
  logic [CENT_W-1:0]     zj;
  logic [4:0]            fold1;
  logic [3:0]            fold2;
  logic [WDAY_W:0]       rem7;
  logic [WDAY_W:0]       wshift;

  // leap rule on the split year
  assign leap = (lo_r == '0) ? (hi_r[1:0] == 2'b00) : (lo_r[1:0] == 2'b00);

  assign len      = month_len(month_r, leap);
  assign len_prev = month_len(month_r - MONTH_W'(1), leap);

  assign fwd_sum   = (JUMP_WIDTH+1)'(n_r) + (JUMP_WIDTH+1)'(day_r);
  assign fwd_fits  = (fwd_sum <= (JUMP_WIDTH+1)'(len));
  assign fwd_end   = (month_r >= MONTH_W'(12)) && (year_r >= YMAX);
  assign back_fits = ((JUMP_WIDTH+1)'(day_r) > (JUMP_WIDTH+1)'(n_r));
  assign back_end  = (month_r <= MONTH_W'(1)) && (year_r <= YEAR_W'(1));

  assign prod = PROD_W'(year_r) * PROD_W'(RECIP_100);

  // zeller terms: january and february count as months 13, 14 of the prior year
  always_comb begin
    if (month_r < MONTH_W'(3)) begin
      mm = month_r + MONTH_W'(12);
      if (lo_r == '0) begin
        zk = CENT_W'(CENT - 1);
        zj = hi_r - CENT_W'(1);
      end else begin
        zk = lo_r - CENT_W'(1);
        zj = hi_r;
      end
    end else begin
      mm = month_r;
      zk = lo_r;
      zj = hi_r;
    end
  end

  // mod 7 by folding octal digits, since 8 is 1 mod 7
  always_comb begin
    fold1  = 5'(sum_r[9:6]) + 5'(sum_r[5:3]) + 5'(sum_r[2:0]);
    fold2  = 4'(fold1[4:3]) + 4'(fold1[2:0]);
    rem7   = (fold2 >= 4'd7) ? fold2 - 4'd7 : fold2;
    wshift = rem7 + 4'd5;
    if (wshift >= 4'd7) begin
      wshift = wshift - 4'd7;
    end
  end

  always_comb begin
    year_nxt  = year_r;
    month_nxt = month_r;
    day_nxt   = day_r;
    hi_nxt    = hi_r;
    lo_nxt    = lo_r;
    n_nxt     = n_r;
    limit_nxt = limit_r;
    sum_nxt   = sum_r;
    stat.walk_done = 1'b0;
    case (cmd.op)
      OP_CAPTURE: begin
        limit_nxt = 1'b0;
        n_nxt     = cmd.unit_step ? JUMP_WIDTH'(1) : JUMP_WIDTH'(in_jump_days);
        if (cmd.load_date) begin
          if (in_load_year < YEAR_W'(1)) begin
            year_nxt = YEAR_W'(1);
          end else if (in_load_year > YMAX) begin
            year_nxt = YMAX;
          end else begin
            year_nxt = in_load_year;
          end
          if (in_load_month < MONTH_W'(1)) begin
            month_nxt = MONTH_W'(1);
          end else if (in_load_month > MONTH_W'(12)) begin
            month_nxt = MONTH_W'(12);
          end else begin
            month_nxt = in_load_month;
          end
          day_nxt = in_load_day;
        end
      end
      OP_SPLIT_HI: hi_nxt = CENT_W'(prod >> RECIP_SHIFT);
      OP_SPLIT_LO: lo_nxt = CENT_W'(year_r - YEAR_W'(hi_r) * YEAR_W'(CENT));
      OP_CLIP: begin
        if (day_r < DAY_W'(1)) begin
          day_nxt = DAY_W'(1);
        end else if (day_r > len) begin
          day_nxt = len;
        end
      end
      OP_FWD: begin
        stat.walk_done = fwd_fits || fwd_end;
        if (fwd_fits) begin
          day_nxt = DAY_W'(fwd_sum);
        end else begin
          n_nxt   = n_r - JUMP_WIDTH'(len) + JUMP_WIDTH'(day_r) - JUMP_WIDTH'(1);
          day_nxt = DAY_W'(1);
          if (month_r >= MONTH_W'(12)) begin
            if (year_r >= YMAX) begin
              year_nxt  = YMAX;
              month_nxt = MONTH_W'(12);
              day_nxt   = DAY_W'(31);
              limit_nxt = 1'b1;
            end else begin
              month_nxt = MONTH_W'(1);
              year_nxt  = year_r + YEAR_W'(1);
              if (lo_r == CENT_W'(CENT - 1)) begin
                lo_nxt = '0;
                hi_nxt = hi_r + CENT_W'(1);
              end else begin
                lo_nxt = lo_r + CENT_W'(1);
              end
            end
          end else begin
            month_nxt = month_r + MONTH_W'(1);
          end
        end
      end
      OP_BACK: begin
        stat.walk_done = back_fits || back_end;
        if (back_fits) begin
          day_nxt = day_r - DAY_W'(n_r);
        end else begin
          n_nxt = n_r - JUMP_WIDTH'(day_r);
          if (month_r <= MONTH_W'(1)) begin
            if (year_r <= YEAR_W'(1)) begin
              year_nxt  = YEAR_W'(1);
              month_nxt = MONTH_W'(1);
              day_nxt   = DAY_W'(1);
              limit_nxt = 1'b1;
            end else begin
              month_nxt = MONTH_W'(12);
              day_nxt   = DAY_W'(31);
              year_nxt  = year_r - YEAR_W'(1);
              if (lo_r == '0) begin
                lo_nxt = CENT_W'(CENT - 1);
                hi_nxt = hi_r - CENT_W'(1);
              end else begin
                lo_nxt = lo_r - CENT_W'(1);
              end
            end
          end else begin
            month_nxt = month_r - MONTH_W'(1);
            day_nxt   = len_prev;
          end
        end
      end
      OP_WD_SUM: begin
        sum_nxt = SUM_W'(day_r) + SUM_W'(zeller_month(mm)) + SUM_W'(zk)
                + SUM_W'(zk[CENT_W-1:2]) + SUM_W'(zj[CENT_W-1:2])
                + SUM_W'({zj, 2'b00}) + SUM_W'(zj);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      year_r  <= YEAR_W'(YEAR_RESET);
      month_r <= MONTH_W'(1);
      day_r   <= DAY_W'(1);
      hi_r    <= CENT_W'(HI_RESET);
      lo_r    <= CENT_W'(LO_RESET);
    end else begin
      year_r  <= year_nxt;
      month_r <= month_nxt;
      day_r   <= day_nxt;
      hi_r    <= hi_nxt;
      lo_r    <= lo_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r     <= n_nxt;
    limit_r <= limit_nxt;
    sum_r   <= sum_nxt;
    if (cmd.op == OP_WD_OUT) begin
      yout_r <= year_r;
      mout_r <= month_r;
      dout_r <= day_r;
      wout_r <= WDAY_W'(wshift);
      lout_r <= leap;
      hout_r <= limit_r;
    end
  end

  assign out_year_now  = yout_r;
  assign out_month_now = mout_r;
  assign out_day_now   = dout_r;
  assign out_weekday   = wout_r;
  assign out_leap_year = lout_r;
  assign out_limit_hit = hout_r;

endmodule

// File: sv/calendar_date_stepper.sv
// ----------------------------------------------------------------------------
// calendar_date_stepper
// Gregorian date counter with step, jump and load commands.
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid / in_stall): one command per transfer; in_kind
//   picks step forward, step back, jump forward, jump back or load date.
//   jump_days is used by jumps, load_* by load. other kind codes report the
//   current date unchanged.
//   result channel (out_valid / out_stall): one result per command with the
//   date, weekday (0 monday .. 6 sunday), leap flag and saturation flag.
// command sequence
//   a step or jump walks the date one month boundary at a time until the
//   remaining days fit in the current month or the date saturates, then
//   sums and registers the weekday; a load splits the year into century
//   and year-in-century and clips the day first; other kind codes go
//   straight to the weekday. one command is in flight at a time; in_stall
//   stays high until the result has been moved into the output register.
// reset
//   the date returns to 2000-01-01 and the output register is empty.
// stall
//   a stalled result holds in the output register; the next command can
//   run meanwhile and waits at its last step until the register frees.
// ----------------------------------------------------------------------------
module calendar_date_stepper
  import cds_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // command channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [KIND_W-1:0]  in_kind,
  input  logic [JDAYS_W-1:0] in_jump_days,
  input  logic [YEAR_W-1:0]  in_load_year,
  input  logic [MONTH_W-1:0] in_load_month,
  input  logic [DAY_W-1:0]   in_load_day,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [YEAR_W-1:0]  out_year_now,
  output logic [MONTH_W-1:0] out_month_now,
  output logic [DAY_W-1:0]   out_day_now,
  output logic [WDAY_W-1:0]  out_weekday,
  output logic               out_leap_year,
  output logic               out_limit_hit
);

  // sequencer to datapath commands, and walk status back
  cds_cmd_t  cmd;
  cds_stat_t stat;

  cds_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_kind   (in_kind),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  // date state, month walk, weekday and the result register
  cds_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_jump_days  (in_jump_days),
    .in_load_year  (in_load_year),
    .in_load_month (in_load_month),
    .in_load_day   (in_load_day),
    .out_year_now  (out_year_now),
    .out_month_now (out_month_now),
    .out_day_now   (out_day_now),
    .out_weekday   (out_weekday),
    .out_leap_year (out_leap_year),
    .out_limit_hit (out_limit_hit)
  );

endmodule

// File: sv/cds_checker.sv
// ----------------------------------------------------------------------------
// cds_checker
// Port-level checks for the date stepper, bound to the top level.
// ----------------------------------------------------------------------------
module cds_checker
  import cds_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [YEAR_W-1:0]  out_year_now,
  input logic [MONTH_W-1:0] out_month_now,
  input logic [DAY_W-1:0]   out_day_now,
  input logic [WDAY_W-1:0]  out_weekday,
  input logic               out_leap_year
);

  // output register is empty after reset
  a_reset_empty: assert property (@(posedge clk) !$past(rst_n) |-> !out_valid)
    else $error("out_valid set right after reset");

  // one command at a time: busy after every command transfer
  a_busy_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second command taken while one is in flight");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_year_now)
      && $stable(out_month_now) && $stable(out_day_now) && $stable(out_weekday))
    else $error("stalled result changed");

  // result has month 1..12, day at least 1, year at least 1 and weekday 0..6
  a_date_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_month_now >= 4'd1 && out_month_now <= 4'd12
      && out_day_now >= 5'd1 && out_weekday <= 3'd6
      && out_year_now >= 14'd1)
    else $error("illegal date or weekday on result");

  // leap flag agrees with the year and february 29
  a_leap_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_leap_year || out_year_now[1:0] == 2'b00)
      && (!(out_month_now == 4'd2 && out_day_now == 5'd29) || out_leap_year))
    else $error("leap flag inconsistent with date");

endmodule

bind calendar_date_stepper cds_checker u_cds_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_year_now  (out_year_now),
  .out_month_now (out_month_now),
  .out_day_now   (out_day_now),
  .out_weekday   (out_weekday),
  .out_leap_year (out_leap_year)
);
